@@ rtl/mvp_pkg.sv @@
package mvp_pkg;

    // Fixed widths of the item fields.
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned COUNT_W = 5;

    // Control broadcast from the sequencer to every multiply-accumulate cell.
    typedef struct packed {
        logic wr;      // coefficient load accepted this cycle
        logic acc_en;  // product register holds a live product
        logic load;    // capture results into the chain and clear accumulators
        logic shift;   // move the result chain one cell toward the output
    } cell_ctrl_t;

endpackage

@@ rtl/mvp_in_if.sv @@
interface mvp_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic [mvp_pkg::IDX_W-1:0]              row_index;
    logic [mvp_pkg::IDX_W-1:0]              col_index;
    logic signed [mvp_pkg::DATA_W-1:0]      value;
    logic [mvp_pkg::DATA_W-1:0]             time_tag;

    modport source (
        output valid, command, row_index, col_index, value, time_tag,
        input  ready
    );
    modport sink (
        input  valid, command, row_index, col_index, value, time_tag,
        output ready
    );
endinterface

@@ rtl/mvp_out_if.sv @@
interface mvp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [mvp_pkg::IDX_W-1:0]              out_row;
    logic signed [mvp_pkg::DATA_W-1:0]      out_value;
    logic                                   is_state;
    logic [mvp_pkg::DATA_W-1:0]             out_time;
    logic                                   last;

    modport source (
        output valid, out_row, out_value, is_state, out_time, last,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_value, is_state, out_time, last,
        output ready
    );
endinterface

@@ rtl/mvp_mac_cell.sv @@
module mvp_mac_cell #(
    parameter int unsigned MAX_COLS  = 16,
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned ROW       = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mvp_pkg::cell_ctrl_t                 ctrl,
    input  logic [mvp_pkg::IDX_W-1:0]           wr_row,
    input  logic [mvp_pkg::IDX_W-1:0]           col,
    input  logic signed [mvp_pkg::DATA_W-1:0]   value,
    input  logic [mvp_pkg::COUNT_W-1:0]         rows_used,
    input  logic signed [mvp_pkg::DATA_W-1:0]   chain_in,
    output logic signed [mvp_pkg::DATA_W-1:0]   result
);

    localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic signed [mvp_pkg::DATA_W-1:0] Q_MAX = {1'b0, {(mvp_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [mvp_pkg::DATA_W-1:0] Q_MIN = {1'b1, {(mvp_pkg::DATA_W-1){1'b0}}};

    // Coefficients of this row, one entry per column.
    logic signed [mvp_pkg::DATA_W-1:0] coef_mem [MAX_COLS];

    logic signed [mvp_pkg::DATA_W-1:0] coef_reg;
    logic signed [mvp_pkg::DATA_W-1:0] elem_reg;
    logic signed [mvp_pkg::ACC_W-1:0]  prod_reg;
    logic signed [mvp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mvp_pkg::ACC_W-1:0]  acc_next;
    logic signed [mvp_pkg::DATA_W-1:0] res_reg;
    logic signed [mvp_pkg::DATA_W-1:0] res_next;

    logic [8:0]                        col_wide;
    logic [CW-1:0]                     addr;
    logic                              wr_hit;
    logic                              row_on;
    logic signed [mvp_pkg::ACC_W:0]    sum;
    logic signed [mvp_pkg::ACC_W-1:0]  scaled;

    assign col_wide = 9'(col);
    assign addr     = col_wide[CW-1:0];
    assign wr_hit   = ctrl.wr && (7'(wr_row) == 7'(ROW)) && (col_wide < 9'(MAX_COLS));
    assign row_on   = 7'(ROW) < 7'(rows_used);

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            coef_mem[addr] <= value;
        end
        coef_reg <= coef_mem[addr];
        elem_reg <= value;
        prod_reg <= coef_reg * elem_reg;
        res_reg  <= res_next;
    end

    // Saturating accumulate at the signed 64-bit bounds.
    always_comb
    begin
        sum = {acc_reg[mvp_pkg::ACC_W-1], acc_reg} + {prod_reg[mvp_pkg::ACC_W-1], prod_reg};
        if (sum[mvp_pkg::ACC_W] != sum[mvp_pkg::ACC_W-1])
        begin
            acc_next = sum[mvp_pkg::ACC_W] ? {1'b1, {(mvp_pkg::ACC_W-1){1'b0}}}
                                           : {1'b0, {(mvp_pkg::ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum[mvp_pkg::ACC_W-1:0];
        end
    end

    // Floor shift to Q16.16 and saturation to 32 bits, applied when results are captured.
    always_comb
    begin
        scaled = acc_reg >>> FRAC_BITS;
        priority if (ctrl.load)
        begin
            if (scaled > 64'(Q_MAX))
            begin
                res_next = Q_MAX;
            end
            else if (scaled < 64'(Q_MIN))
            begin
                res_next = Q_MIN;
            end
            else
            begin
                res_next = scaled[mvp_pkg::DATA_W-1:0];
            end
        end
        else if (ctrl.shift)
        begin
            res_next = chain_in;
        end
        else
        begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.load)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en && row_on)
        begin
            acc_reg <= acc_next;
        end
    end

    assign result = res_reg;

endmodule

@@ rtl/matrix_vector_projection_unit.sv @@
// Matrix-vector projection unit, Q16.16 fixed point.
//
// Items enter on in_ch (valid/ready). A command of 0 loads one matrix
// coefficient at (row_index, col_index); a command of 1 carries one vector
// element with its column. Results leave on out_ch, one item per row in use,
// in row order, with last set on the final row. The APB port writes and reads
// rows_in_use (0x0), cols_in_use (0x4) and route_to_state (0x8).
//
// The datapath is a row of identical cells, one per matrix row, each holding
// its row's coefficients and a 64-bit accumulator. Loads and elements are taken
// one per cycle while in_ch.ready is high. The closing element (last column in
// use) reads memory at its accepting edge, then multiplies, accumulates and
// captures the results; the first result is then valid in the output register
// of cell 0, and the rest shift down the cell chain toward it one per cycle
// while the receiver takes them. From the closing element until the last result
// is taken, in_ch.ready stays low, so the next vector waits for the last result.
// If the receiver stalls, the current result holds and the chain waits.
// Reset clears the accumulators and the control state and sets the registers
// to 16 rows, 16 columns and state routing; the coefficient store is not
// cleared and must be loaded before use.
module matrix_vector_projection_unit #(
    parameter int unsigned MAX_ROWS  = 16,
    parameter int unsigned MAX_COLS  = 16,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mvp_in_if.sink      in_ch,
    mvp_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [mvp_pkg::COUNT_W-1:0] ROWS_RST =
        mvp_pkg::COUNT_W'((MAX_ROWS < 16) ? MAX_ROWS : 16);
    localparam logic [mvp_pkg::COUNT_W-1:0] COLS_RST =
        mvp_pkg::COUNT_W'((MAX_COLS < 16) ? MAX_COLS : 16);

    // Register indexes on paddr[3:2].
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_ROUTE = 2'd2;

    // Clamp a count to 1 .. max.
    function automatic logic [mvp_pkg::COUNT_W-1:0] clamp_count(
        input logic [mvp_pkg::COUNT_W-1:0] v,
        input int unsigned                 max_cnt
    );
        logic [mvp_pkg::COUNT_W-1:0] r;
        if (v == '0)
        begin
            r = mvp_pkg::COUNT_W'(1);
        end
        else if (32'(v) > max_cnt)
        begin
            r = mvp_pkg::COUNT_W'(max_cnt);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [mvp_pkg::COUNT_W-1:0] rows_reg;
    logic [mvp_pkg::COUNT_W-1:0] cols_reg;
    logic                        route_reg;
    logic                        cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_RST;
            cols_reg  <= COLS_RST;
            route_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ROWS:  rows_reg  <= clamp_count(pwdata[4:0], MAX_ROWS);
                REG_COLS:  cols_reg  <= clamp_count(pwdata[4:0], MAX_COLS);
                REG_ROUTE: route_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROWS:  prdata = 32'(rows_reg);
            REG_COLS:  prdata = 32'(cols_reg);
            REG_ROUTE: prdata = 32'(route_reg);
            default:   prdata = '0;
        endcase
    end

    // Input decode.
    logic in_acc;
    logic elem_ok;
    logic elem_close;

    assign in_acc     = in_ch.valid && in_ch.ready;
    assign elem_ok    = in_acc && in_ch.command && (5'(in_ch.col_index) < cols_reg);
    assign elem_close = elem_ok && ((5'(in_ch.col_index) + 5'd1) == cols_reg);

    // Element pipeline tracking: read, multiply, accumulate, capture.
    logic           s1_vld_reg;
    logic           s1_close_reg;
    logic           s2_vld_reg;
    logic           s2_close_reg;
    logic           s3_close_reg;
    logic           busy_reg;
    logic           out_vld_reg;
    logic [RIW-1:0] idx_reg;
    logic [31:0]    tag_reg;
    logic           is_state_reg;
    logic           out_acc;
    logic           out_last;

    assign out_acc  = out_vld_reg && out_ch.ready;
    assign out_last = (7'(idx_reg) + 7'd1) == 7'(rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_close_reg <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_close_reg <= 1'b0;
            s3_close_reg <= 1'b0;
            busy_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            s1_vld_reg   <= elem_ok;
            s1_close_reg <= elem_close;
            s2_vld_reg   <= s1_vld_reg;
            s2_close_reg <= s1_close_reg;
            s3_close_reg <= s2_close_reg;
            if (elem_close)
            begin
                busy_reg <= 1'b1;
            end
            if (s3_close_reg)
            begin
                out_vld_reg <= 1'b1;
                idx_reg     <= '0;
            end
            else if (out_acc)
            begin
                idx_reg <= idx_reg + RIW'(1);
                if (out_last)
                begin
                    out_vld_reg <= 1'b0;
                    busy_reg    <= 1'b0;
                end
            end
        end
    end

    // Time tag and routing are taken from the closing element.
    always_ff @(posedge clk)
    begin
        if (elem_close)
        begin
            tag_reg      <= in_ch.time_tag;
            is_state_reg <= route_reg;
        end
    end

    assign in_ch.ready = !busy_reg;

    // Cell chain.
    mvp_pkg::cell_ctrl_t               ctrl;
    logic signed [mvp_pkg::DATA_W-1:0] chain [MAX_ROWS+1];

    assign ctrl.wr     = in_acc && !in_ch.command;
    assign ctrl.acc_en = s2_vld_reg;
    assign ctrl.load   = s3_close_reg;
    assign ctrl.shift  = out_acc;
    assign chain[MAX_ROWS] = '0;

    for (genvar r = 0; r < MAX_ROWS; r++)
    begin : g_cell
        mvp_mac_cell #(
            .MAX_COLS  (MAX_COLS),
            .FRAC_BITS (FRAC_BITS),
            .ROW       (r)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_row    (in_ch.row_index),
            .col       (in_ch.col_index),
            .value     (in_ch.value),
            .rows_used (rows_reg),
            .chain_in  (chain[r+1]),
            .result    (chain[r])
        );
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.out_row   = mvp_pkg::IDX_W'(idx_reg);
    assign out_ch.out_value = chain[0];
    assign out_ch.is_state  = is_state_reg;
    assign out_ch.out_time  = tag_reg;
    assign out_ch.last      = out_last;

    // A pending result always belongs to a vector that still blocks the input.
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> busy_reg)
        else $error("result pending while input is open");

    // Captured results are never overwritten before they are all delivered.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s3_close_reg |-> !out_vld_reg)
        else $error("result chain reloaded while draining");

    // The row counter stays within the rows in use while draining.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (7'(idx_reg) < 7'(rows_reg)))
        else $error("row counter beyond rows in use");

    // Taking the final row reopens the input.
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_last) |=> (!busy_reg && !out_vld_reg))
        else $error("input not reopened after final row");

endmodule
